// ----- rtl/bfpa_pkg.sv -----
// Shared types and constants for the best-fit pool allocator.
package bfpa_pkg;

  localparam int unsigned PoolBytesDefault   = 65536;
  localparam int unsigned MaxSegmentsDefault = 32;

  localparam int unsigned SizeW   = 17;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned StatusW = 3;

  localparam logic [StatusW-1:0] StOk           = 3'd0;
  localparam logic [StatusW-1:0] StNoMemory     = 3'd1;
  localparam logic [StatusW-1:0] StTableFull    = 3'd2;
  localparam logic [StatusW-1:0] StNotAllocated = 3'd3;
  localparam logic [StatusW-1:0] StZeroSize     = 3'd4;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic split;
    logic mark_used;
    logic free_mark;
    logic shift_step;
    logic merge_next;
    logic merge_prev;
    logic finish;
  } bfpa_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_free_op;
    logic zero_size;
    logic found;
    logic exact;
    logic table_full;
    logic shift_done;
    logic next_free;
    logic prev_free;
  } bfpa_status_t;

endpackage

// ----- rtl/bfpa_datapath.sv -----
// Segment table, scan, shift and merge datapath for the pool allocator.
module bfpa_datapath #(
  parameter int unsigned MaxSegments = bfpa_pkg::MaxSegmentsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          operation_i,
  input  logic [bfpa_pkg::SizeW-1:0]    request_size_i,
  input  logic [bfpa_pkg::OffsetW-1:0]  block_offset_i,
  input  bfpa_pkg::bfpa_cmd_t           cmd_i,
  output bfpa_pkg::bfpa_status_t        sts_o,
  output logic [bfpa_pkg::OffsetW-1:0]  granted_offset_o,
  output logic [bfpa_pkg::SizeW-1:0]    bytes_used_o
);
  import bfpa_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam int unsigned LenW = SizeW;

  logic [OffsetW-1:0] start_q [MaxSegments];
  logic [LenW-1:0]    len_q   [MaxSegments];
  logic [MaxSegments-1:0] free_q;
  logic [CntW-1:0]    count_q;
  logic [SizeW-1:0]   used_q;

  logic               op_q;
  logic [SizeW-1:0]   size_q;
  logic [OffsetW-1:0] off_q;
  logic [CntW-1:0]    scan_q;
  logic               found_q;
  logic [IdxW-1:0]    best_q;
  logic [LenW-1:0]    diff_q;
  logic [CntW-1:0]    shift_q;
  logic [OffsetW-1:0] grant_q;

  logic [IdxW-1:0]    si;
  logic [LenW-1:0]    size_l;
  logic               hit;
  logic [LenW-1:0]    cdiff;
  logic [CntW-1:0]    best_c;
  logic               nxt_ok, prv_ok;
  logic [IdxW-1:0]    sh_i;

  assign si     = scan_q[IdxW-1:0];
  assign size_l = LenW'(size_q);
  assign cdiff  = len_q[si] - size_l;
  assign hit    = op_q ? (!free_q[si] && start_q[si] == off_q)
                       : (free_q[si] && len_q[si] >= size_l &&
                          (!found_q || cdiff < diff_q));
  assign best_c = CntW'(best_q);
  assign nxt_ok = (best_c + CntW'(1)) < count_q;
  assign prv_ok = best_q != '0;
  assign sh_i   = shift_q[IdxW-1:0];

  assign sts_o.scan_done  = scan_q >= count_q || (op_q && found_q);
  assign sts_o.is_free_op = op_q;
  assign sts_o.zero_size  = size_q == '0;
  assign sts_o.found      = found_q;
  assign sts_o.exact      = diff_q == '0;
  assign sts_o.table_full = count_q >= CntW'(MaxSegments);
  assign sts_o.shift_done = cmd_i.split  ? 1'b0 :
                            cmd_i.finish ? ((shift_q + CntW'(1)) >= count_q) :
                                           (shift_q <= best_c + CntW'(1));
  assign sts_o.next_free  = nxt_ok && free_q[IdxW'(best_c + CntW'(1))];
  assign sts_o.prev_free  = prv_ok && free_q[best_q - IdxW'(1)];

  assign granted_offset_o = grant_q;
  assign bytes_used_o     = used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxSegments; k++) begin
        start_q[k] <= '0;
        len_q[k]   <= (k == 0) ? LenW'(PoolBytesDefault) : '0;
      end
      free_q  <= {{(MaxSegments-1){1'b0}}, 1'b1};
      count_q <= CntW'(1);
      used_q  <= '0;
      scan_q  <= '0;
      found_q <= 1'b0;
      shift_q <= '0;
    end else begin
      if (cmd_i.load) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.scan_step && !sts_o.scan_done) begin
        scan_q <= scan_q + CntW'(1);
        if (hit) begin
          found_q <= 1'b1;
          best_q  <= si;
          diff_q  <= cdiff;
        end
      end
      if (cmd_i.mark_used) begin
        free_q[best_q] <= 1'b0;
        used_q <= used_q + size_q;
      end
      if (cmd_i.split) begin
        shift_q <= count_q;
      end
      if (cmd_i.shift_step) begin
        if (shift_q > best_c + CntW'(1)) begin
          start_q[sh_i] <= start_q[sh_i - IdxW'(1)];
          len_q[sh_i]   <= len_q[sh_i - IdxW'(1)];
          free_q[sh_i]  <= free_q[sh_i - IdxW'(1)];
          shift_q <= shift_q - CntW'(1);
        end else begin
          len_q[best_q]  <= size_l;
          free_q[best_q] <= 1'b0;
          start_q[IdxW'(best_c + CntW'(1))] <= start_q[best_q] + OffsetW'(size_q);
          len_q[IdxW'(best_c + CntW'(1))]   <= diff_q;
          free_q[IdxW'(best_c + CntW'(1))]  <= 1'b1;
          count_q <= count_q + CntW'(1);
          used_q  <= used_q + size_q;
          shift_q <= '0;
        end
      end
      if (cmd_i.free_mark) begin
        free_q[best_q] <= 1'b1;
        used_q <= used_q - SizeW'(len_q[best_q]);
      end
      if (cmd_i.merge_next) begin
        len_q[best_q] <= len_q[best_q] + len_q[IdxW'(best_c + CntW'(1))];
        shift_q <= best_c + CntW'(1);
      end
      if (cmd_i.merge_prev) begin
        len_q[best_q - IdxW'(1)] <= len_q[best_q - IdxW'(1)] + len_q[best_q];
        shift_q <= best_c;
      end
      if (cmd_i.finish && shift_q != '0 && (shift_q + CntW'(1)) < count_q) begin
        start_q[sh_i] <= start_q[IdxW'(shift_q + CntW'(1))];
        len_q[sh_i]   <= len_q[IdxW'(shift_q + CntW'(1))];
        free_q[sh_i]  <= free_q[IdxW'(shift_q + CntW'(1))];
        shift_q <= shift_q + CntW'(1);
      end else if (cmd_i.finish && shift_q != '0) begin
        free_q[sh_i] <= 1'b0;
        count_q <= count_q - CntW'(1);
        shift_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      size_q <= request_size_i;
      off_q  <= block_offset_i;
    end
    if (cmd_i.mark_used || (cmd_i.shift_step && shift_q <= best_c + CntW'(1))) begin
      grant_q <= start_q[best_q];
    end
    if (cmd_i.load) begin
      grant_q <= '0;
    end
  end

endmodule

// ----- rtl/bfpa_ctrl.sv -----
// Request sequencing state machine for the pool allocator.
module bfpa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  bfpa_pkg::bfpa_status_t        sts_i,
  output bfpa_pkg::bfpa_cmd_t           cmd_o,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [bfpa_pkg::StatusW-1:0]  status_o
);
  import bfpa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_SCAN   = 8'b00000010,
    S_DECIDE = 8'b00000100,
    S_SHIFT  = 8'b00001000,
    S_MNEXT  = 8'b00010000,
    S_MPREV  = 8'b00100000,
    S_DROP   = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [StatusW-1:0] st_q, st_d;
  logic drop_pend_q, drop_pend_d;

  assign busy_o   = state_q != S_IDLE;
  assign done_o   = state_q == S_DONE;
  assign status_o = st_q;

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    drop_pend_d = drop_pend_q;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        st_d    = StOk;
        state_d = S_DONE;
        if (sts_i.is_free_op) begin
          if (!sts_i.found) st_d = StNotAllocated;
          else begin
            cmd_o.free_mark = 1'b1;
            drop_pend_d     = sts_i.prev_free;
            state_d = sts_i.next_free ? S_MNEXT : (sts_i.prev_free ? S_MPREV : S_DONE);
          end
        end else if (sts_i.zero_size) st_d = StZeroSize;
        else if (!sts_i.found) st_d = StNoMemory;
        else if (sts_i.exact) cmd_o.mark_used = 1'b1;
        else if (sts_i.table_full) st_d = StTableFull;
        else begin
          cmd_o.split = 1'b1;
          state_d     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_done) state_d = S_DONE;
      end
      S_MNEXT: begin
        cmd_o.merge_next = 1'b1;
        state_d = S_DROP;
      end
      S_MPREV: begin
        cmd_o.merge_prev = 1'b1;
        drop_pend_d = 1'b0;
        state_d = S_DROP;
      end
      S_DROP: begin
        cmd_o.finish = 1'b1;
        if (sts_i.shift_done) state_d = drop_pend_q ? S_MPREV : S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= StOk;
      drop_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      drop_pend_q <= drop_pend_d;
    end
  end

endmodule

// ----- rtl/best_fit_pool_allocator.sv -----
// Best-fit pool allocator: top level joining controller and datapath.
// A request scans the segment table and then decides; a free ends its scan at the matching entry.
// The result strobe follows the decision and any shift or merge steps.
// A split shifts later segments up; a free that merges removes each absorbed segment by shifting later ones down.
// One request at a time; busy stays high through the strobe cycle.
// Reset: one free segment covering the pool, no bytes in use; the receiver cannot stall.
module best_fit_pool_allocator #(
  parameter int unsigned MaxSegments = bfpa_pkg::MaxSegmentsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic [bfpa_pkg::SizeW-1:0]    request_size_i,
  input  logic [bfpa_pkg::OffsetW-1:0]  block_offset_i,
  output logic                          done_o,
  output logic [bfpa_pkg::OffsetW-1:0]  granted_offset_o,
  output logic [bfpa_pkg::StatusW-1:0]  status_o,
  output logic [bfpa_pkg::SizeW-1:0]    bytes_used_o
);
  import bfpa_pkg::*;

  bfpa_cmd_t    cmd;
  bfpa_status_t sts;

  bfpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_o (status_o)
  );

  bfpa_datapath #(
    .MaxSegments (MaxSegments)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .operation_i      (operation_i),
    .request_size_i   (request_size_i),
    .block_offset_i   (block_offset_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .granted_offset_o (granted_offset_o),
    .bytes_used_o     (bytes_used_o)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe without busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StOk) |-> granted_offset_o == '0)
    else $error("failed request with nonzero offset");
  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");
`endif

endmodule
